// File: design/pjtd_pkg.sv
// ----------------------------------------------------------------------------
// pjtd_pkg
// Shared types and codes of the periodic job tick divider.
// ----------------------------------------------------------------------------
package pjtd_pkg;

  localparam int DATA_W = 32;
  localparam int SLOT_W = 4;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_ADD  = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] ratio;
    logic [DATA_W-1:0] count;
  } pjtd_entry_t;

  localparam int ENTRY_W = $bits(pjtd_entry_t);

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } pjtd_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } pjtd_div_rsp_t;

endpackage

// File: design/pjtd_ram.sv
// ----------------------------------------------------------------------------
// pjtd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pjtd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/pjtd_div.sv
// ----------------------------------------------------------------------------
// pjtd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pjtd_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pjtd_pkg::pjtd_div_req_t req,
  output pjtd_pkg::pjtd_div_rsp_t rsp
);
  import pjtd_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              q_bit;

  always_comb begin
    rem_sh   = {rem_r, q_r[DATA_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    q_bit    = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = q_bit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      q_nxt   = {q_r[DATA_W-2:0], q_bit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// File: design/periodic_job_tick_divider.sv
// ----------------------------------------------------------------------------
// periodic_job_tick_divider
// Table of periodic jobs driven by a base tick; adds jobs and reports firings.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_action, in_job_interval
//   out     | output    | out_valid / out_ready| out_kind, out_slot, out_status,
//           |           |                      | out_last
//   cfg     | input     | cfg_valid / cfg_ready| cfg_base_interval
//
// One request at a time. An add waits for the serial 32-step divider. A
// tick reads, updates and writes back each occupied slot through the table
// RAM's single read port, and a firing found while an earlier one is still
// pending passes through S_PUSH. A stalled output holds up the request.
// Reset clears the job count; no clearing pass is needed since only added
// slots are ever read.
// ----------------------------------------------------------------------------
module periodic_job_tick_divider #(
  parameter int MAX_JOBS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic signed [31:0]          in_job_interval,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [pjtd_pkg::SLOT_W-1:0] out_slot,
  output logic                        out_status,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [31:0]                 cfg_base_interval
);
  import pjtd_pkg::*;

  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ACK  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     job_count_r, job_count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [CW-1:0]     pend_slot_r, pend_slot_nxt;
  logic [CW-1:0]     ack_slot_r, ack_slot_nxt;
  logic              ack_full_r, ack_full_nxt;
  logic [DATA_W-1:0] base_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic [DATA_W-1:0] base_eff;
  logic [DATA_W-1:0] raw;
  logic [DATA_W-1:0] interval;
  logic [DATA_W-1:0] cnt_inc;
  logic              fire;
  logic [CW-1:0]     idx_inc;

  pjtd_div_req_t     div_req;
  pjtd_div_rsp_t     div_rsp;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  pjtd_entry_t       ram_wr_data;
  logic              ram_rd_en;
  logic [ENTRY_W-1:0] ram_rd_raw;
  pjtd_entry_t       rd_entry;

  pjtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pjtd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_JOBS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_raw)
  );

  assign rd_entry  = pjtd_entry_t'(ram_rd_raw);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign base_eff  = (base_r == '0) ? DATA_W'(1) : base_r;
  assign raw       = DATA_W'(in_job_interval);
  assign interval  = ((raw == '0) || raw[DATA_W-1] || (raw < base_eff)) ? base_eff : raw;
  assign cnt_inc   = rd_entry.count + 1'b1;
  assign fire      = (cnt_inc >= rd_entry.ratio);
  assign idx_inc   = idx_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    job_count_nxt  = job_count_r;
    idx_nxt        = idx_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    ack_slot_nxt   = ack_slot_r;
    ack_full_nxt   = ack_full_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    div_req.start    = 1'b0;
    div_req.dividend = interval;
    div_req.divisor  = base_eff;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = idx_r[AW-1:0];
    ram_wr_data      = '{ratio: rd_entry.ratio, count: fire ? '0 : cnt_inc};
    ram_rd_en        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACTION_ADD) begin
            if (job_count_r >= CW'(MAX_JOBS)) begin
              ack_full_nxt = STATUS_FULL;
              ack_slot_nxt = '0;
              state_nxt    = S_ACK;
            end else begin
              ack_full_nxt  = STATUS_OK;
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = (job_count_r == '0) ? S_FIN : S_RD;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ram_wr_en     = 1'b1;
          ram_wr_addr   = job_count_r[AW-1:0];
          ram_wr_data   = '{ratio: div_rsp.quotient, count: '0};
          ack_slot_nxt  = job_count_r;
          job_count_nxt = job_count_r + 1'b1;
          state_nxt     = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_ADD;
          out_slot_nxt   = SLOT_W'(ack_slot_r);
          out_status_nxt = ack_full_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        // write back this slot; the next read is always a different slot
        if (rd_entry.ratio != '0) begin
          ram_wr_en = 1'b1;
        end
        if ((rd_entry.ratio != '0) && fire && pend_v_r) begin
          state_nxt = S_PUSH;
        end else begin
          if ((rd_entry.ratio != '0) && fire) begin
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = idx_r;
          end
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == job_count_r) ? S_FIN : S_RD;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_FIRE;
          out_slot_nxt   = SLOT_W'(pend_slot_r);
          out_status_nxt = STATUS_OK;
          out_last_nxt   = 1'b0;
          pend_slot_nxt  = idx_r;
          idx_nxt        = idx_inc;
          state_nxt      = (idx_inc == job_count_r) ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_FIRE;
          out_slot_nxt   = SLOT_W'(pend_slot_r);
          out_status_nxt = STATUS_OK;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_count_r <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= DATA_W'(1);
    end else begin
      state_r     <= state_nxt;
      job_count_r <= job_count_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_base_interval;
      end
    end
    pend_slot_r  <= pend_slot_nxt;
    ack_slot_r   <= ack_slot_nxt;
    ack_full_r   <= ack_full_nxt;
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// File: design/pjtd_checker.sv
// ----------------------------------------------------------------------------
// pjtd_checker
// Port-level checks of the periodic job tick divider, bound to the top level.
// ----------------------------------------------------------------------------
module pjtd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [pjtd_pkg::SLOT_W-1:0] out_slot,
  input logic                        out_status,
  input logic                        out_last
);
  import pjtd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_slot) && $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ADD) |-> out_last)
    else $error("add acknowledgement not marked last");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FIRE) |-> (out_status == STATUS_OK))
    else $error("fire result with full status");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while busy");

endmodule

bind periodic_job_tick_divider pjtd_checker u_pjtd_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the periodic job tick divider with add and tick requests: a short
// table of directed rows first, then three randomized phases, each with its
// own base interval and its own mix of idle cycles on both channels. A job-table
// model inside this file predicts every firing and the add acknowledgements of the
// random phases (directed rows give their own); a monitor compares each accepted result in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pjtd_pkg::*;

  localparam int  MAX_JOBS   = 16;
  localparam time CLK_PERIOD = 10ns;
  localparam int  SETTLE     = 60;
  localparam int  RX_HOLD    = 400;
  localparam int  CYCLE_CAP  = 400000;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              status;
    logic              last;
  } job_result_t;

  typedef struct packed {
    logic        is_cfg;
    logic        action;
    logic [31:0] value;
    logic        typed;
    job_result_t res;
  } dir_row_t;

  localparam job_result_t NO_RES = '0;

  localparam int N_DIR = 20;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{1'b0, ACTION_ADD,  32'h0000_0000, 1'b1, '{KIND_ADD, 4'd0, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_ADD,  32'h8000_0000, 1'b1, '{KIND_ADD, 4'd1, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_ADD,  32'h7FFF_FFFF, 1'b1, '{KIND_ADD, 4'd2, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_ADD,  32'hFFFF_FFFF, 1'b1, '{KIND_ADD, 4'd3, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_TICK, 32'hFFFF_FFFF, 1'b0, NO_RES},
    '{1'b0, ACTION_TICK, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b1, ACTION_TICK, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b0, ACTION_ADD,  32'h0000_0001, 1'b1, '{KIND_ADD, 4'd4, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_ADD,  32'h0000_0003, 1'b1, '{KIND_ADD, 4'd5, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_TICK, 32'h5555_5555, 1'b0, NO_RES},
    '{1'b0, ACTION_TICK, 32'hAAAA_AAAA, 1'b0, NO_RES},
    '{1'b0, ACTION_TICK, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b1, ACTION_TICK, 32'h0000_0005, 1'b0, NO_RES},
    '{1'b0, ACTION_ADD,  32'h0000_0004, 1'b1, '{KIND_ADD, 4'd6, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_ADD,  32'h0000_0011, 1'b1, '{KIND_ADD, 4'd7, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_TICK, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b0, ACTION_TICK, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b1, ACTION_TICK, 32'hFFFF_FFFF, 1'b0, NO_RES},
    '{1'b0, ACTION_ADD,  32'h7FFF_FFFF, 1'b1, '{KIND_ADD, 4'd8, STATUS_OK, 1'b1}},
    '{1'b0, ACTION_TICK, 32'h0000_0000, 1'b0, NO_RES}
  };

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic              in_action         = ACTION_TICK;
  logic [31:0]       in_job_interval   = '0;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic              out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic              out_status;
  logic              out_last;
  logic              cfg_valid         = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_base_interval = '0;

  int          tx_idle_pct  = 21;
  int          rx_idle_pct  = 66;
  logic        rx_hold_req  = 1'b0;
  int          rx_hold_left = 0;
  int          err_cnt      = 0;
  int          cycle_cnt    = 0;

  job_result_t awaited_results [$];

  logic [31:0] model_base = 32'd1;
  int unsigned model_jobs = 0;
  logic [31:0] model_ratio [MAX_JOBS];
  logic [31:0] model_count [MAX_JOBS];

  periodic_job_tick_divider #(
    .MAX_JOBS(MAX_JOBS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_job_interval  (in_job_interval),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_base_interval(cfg_base_interval)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold off the result channel for a long stretch on request
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left <= RX_HOLD;
      out_ready    <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    job_result_t got;
    job_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_slot, out_status, out_last};
      if (awaited_results.size() == 0) begin
        err_cnt <= err_cnt + 1;
        $display("%0t: unexpected result kind=%0d slot=%0d status=%0d last=%0d",
                 $time, got.kind, got.slot, got.status, got.last);
      end else begin
        want = awaited_results.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot ||
            got.status !== want.status || got.last !== want.last) begin
          err_cnt <= err_cnt + 1;
          $display("%0t: mismatch expected kind=%0d slot=%0d status=%0d last=%0d, %s",
                   $time, want.kind, want.slot, want.status, want.last,
                   $sformatf("actual kind=%0d slot=%0d status=%0d last=%0d",
                             got.kind, got.slot, got.status, got.last));
        end
      end
    end
  end

  function automatic void step_job_table(input logic action, input logic [31:0] interval,
                                         output job_result_t res [$]);
    logic [31:0] base;
    logic [31:0] eff;
    res  = {};
    base = (model_base == 32'd0) ? 32'd1 : model_base;
    if (action == ACTION_ADD) begin
      if (model_jobs >= MAX_JOBS) begin
        res.push_back('{KIND_ADD, 4'd0, STATUS_FULL, 1'b1});
        return;
      end
      eff = interval;
      if (interval == 32'd0 || interval[31] || interval < base) eff = base;
      model_ratio[model_jobs] = eff / base;
      model_count[model_jobs] = 32'd0;
      res.push_back('{KIND_ADD, SLOT_W'(model_jobs), STATUS_OK, 1'b1});
      model_jobs++;
    end else begin
      for (int i = 0; i < model_jobs; i++) begin
        if (model_ratio[i] != 32'd0) begin
          model_count[i] = model_count[i] + 32'd1;
          if (model_count[i] >= model_ratio[i]) begin
            model_count[i] = 32'd0;
            res.push_back('{KIND_FIRE, SLOT_W'(i), STATUS_OK, 1'b0});
          end
        end
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic logic [31:0] pick_interval(input logic [31:0] base);
    logic [63:0] wide;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        wide = 64'(base) * 64'($urandom_range(6, 1)) + 64'($urandom_range(base - 32'd1));
        return (wide > 64'h7FFF_FFFF) ? ($urandom & 32'h7FFF_FFFF) : wide[31:0];
      end
      5:       return $urandom | 32'h8000_0000;
      6:       return $urandom;
      7:       return (base > 32'd1) ? 32'($urandom_range(base - 32'd1)) : 32'd0;
      8:       return 32'd0;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic send_request(input logic action, input logic [31:0] interval,
                              input logic hold_rx, input logic typed,
                              input job_result_t typed_res);
    job_result_t res [$];
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= action;
    in_job_interval <= interval;
    if (hold_rx) rx_hold_req <= 1'b1;
    do begin
      @(posedge clk);
      if (rx_hold_req) rx_hold_req <= 1'b0;
    end while (!in_ready);
    step_job_table(action, interval, res);
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      foreach (res[k]) awaited_results.push_back(res[k]);
    end
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    wait_drained(SETTLE);
    cfg_valid         <= 1'b1;
    cfg_base_interval <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    model_base = value;
  endtask

  task automatic run_phase(input int n_items, input int job_cap, input int add_pct,
                           input int hold_at, input int pause_at, input bit fill);
    logic        action;
    logic [31:0] interval;
    logic [31:0] base;
    for (int n = 0; n < n_items; n++) begin
      if (n == pause_at) wait_drained(0);
      base = (model_base == 32'd0) ? 32'd1 : model_base;
      if (fill && model_jobs < MAX_JOBS) begin
        action = ACTION_ADD;
      end else if ($urandom_range(99) < add_pct &&
                   (model_jobs < job_cap || model_jobs >= MAX_JOBS)) begin
        action = ACTION_ADD;
      end else begin
        action = ACTION_TICK;
      end
      interval = (action == ACTION_ADD) ? pick_interval(base) : $urandom;
      send_request(action, interval, n == hold_at, 1'b0, NO_RES);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].is_cfg) begin
        write_base(DIRECTED[r].value);
      end else begin
        send_request(DIRECTED[r].action, DIRECTED[r].value, 1'b0,
                     DIRECTED[r].typed, DIRECTED[r].res);
      end
    end

    write_base(32'($urandom_range(8, 1)));
    run_phase(30, 12, 20, -1, -1, 1'b0);

    tx_idle_pct  = 66;
    rx_idle_pct <= 21;
    write_base($urandom);
    run_phase(30, 14, 20, -1, -1, 1'b0);

    tx_idle_pct  = 0;
    rx_idle_pct <= 0;
    write_base(32'($urandom_range(6, 2)));
    run_phase(40, MAX_JOBS, 25, 10, 25, 1'b1);

    wait_drained(SETTLE);
    if (err_cnt == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
